### design/parametric_curve_point_tangent_assert.svh
// ----------------------------------------------------------------------------
// parametric curve point and tangent: assertion macros
// concurrent checks, clocked on the rising edge, off while reset is low
// ----------------------------------------------------------------------------
`ifndef PARAMETRIC_CURVE_POINT_TANGENT_ASSERT_SVH
`define PARAMETRIC_CURVE_POINT_TANGENT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PCPT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define PCPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/pcpt_pkg.sv
// ----------------------------------------------------------------------------
// pcpt_pkg
// constants, codes and helpers of the parametric curve point and tangent unit
// ----------------------------------------------------------------------------
`default_nettype none

package pcpt_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int ATAN_LEN          = 30;

    // register map
    typedef enum logic [2:0] {
        REG_CURVE_KIND,
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_RADIUS_X,
        REG_RADIUS_Y,
        REG_PITCH
    } cfg_index_t;

    // curve kinds, the unused code behaves as the circle
    typedef enum logic [1:0] {
        KIND_CIRCLE,
        KIND_ELLIPSE,
        KIND_HELIX
    } curve_kind_t;

    localparam logic [63:0]        PI_Q62            = 64'hC90FDAA22168C235;
    localparam logic signed [34:0] HALF_PI_Q30       = 35'sd1686629713;
    localparam logic signed [34:0] PI_Q30            = 35'sd3373259426;
    localparam logic signed [34:0] THREE_HALF_PI_Q30 = 35'sd5059889139;
    localparam logic signed [34:0] TWO_PI_Q30        = 35'sd6746518852;
    localparam logic signed [32:0] GAIN_Q30          = 33'sd652032874;
    localparam logic [31:0]        INV_TWO_PI_Q32    = 32'd683565276;

    typedef logic [31:0] atan_tab_t [ATAN_LEN];

    localparam atan_tab_t ATAN_Q30 = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001
    };

    // 2*pi with f fraction bits, rounded to nearest
    function automatic logic [63:0] two_pi_qf(input int f);
        return (PI_Q62 + (64'd1 << (60 - f))) >> (61 - f);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

`default_nettype wire

### design/parametric_curve_point_tangent.sv
// ----------------------------------------------------------------------------
// parametric_curve_point_tangent
// point and first derivative of a circle, ellipse or vertical helix at angle t
//
//   channel   direction  handshake              payload
//   in        sink       in_valid / in_ready    angle
//   out       source     out_valid / out_ready  pos_x/y/z, slope_x/y/z
//   cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one transaction per cycle in and out while the output is not stalled;
// the rotation pipeline has one stage per rotation
// reset empties the pipeline and loads the register defaults
// a waiting result stalls the pipeline only when the last stage is occupied,
// so bubbles still close up behind it; config writes complete every cycle
// ----------------------------------------------------------------------------
`default_nettype none

`include "parametric_curve_point_tangent_assert.svh"

module parametric_curve_point_tangent
    import pcpt_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire logic signed [31:0] angle,

    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic signed [31:0] pos_x,
    output      logic signed [31:0] pos_y,
    output      logic signed [31:0] pos_z,
    output      logic signed [31:0] slope_x,
    output      logic signed [31:0] slope_y,
    output      logic signed [31:0] slope_z,

    input  wire logic               cfg_valid,
    output      logic               cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);

    localparam logic [63:0] TWO_PI_QF = two_pi_qf(FRACTION_BITS);
    localparam int          MW        = $clog2(TWO_PI_QF);
    localparam logic [MW-1:0] M_W     = MW'(TWO_PI_QF);
    localparam logic [31:0] M32       = 32'(TWO_PI_QF);
    localparam logic [31:0] RECIP     = 32'(64'h1_0000_0000 / TWO_PI_QF);
    localparam logic [MW-1:0] WRAP_OFF    = MW'(64'h8000_0000 % TWO_PI_QF);
    localparam logic [MW-1:0] WRAP_ADD    = MW'(TWO_PI_QF - (64'h8000_0000 % TWO_PI_QF));
    localparam int          QSH       = 30 - FRACTION_BITS;
    localparam int          N         = CORDIC_STAGES;
    localparam int          D         = CORDIC_STAGES + 10;
    localparam int          XW        = 33;
    localparam logic signed [63:0] RND29 = 64'sd536870912;
    localparam logic [63:0] RND_F     = 64'd1 << (FRACTION_BITS - 1);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [1:0]         curve_kind_reg;
    logic signed [31:0] center_x_reg;
    logic signed [31:0] center_y_reg;
    logic [30:0]        radius_x_reg;
    logic [30:0]        radius_y_reg;
    logic signed [31:0] pitch_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_kind_reg <= KIND_CIRCLE;
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            radius_x_reg   <= 31'd65536;
            radius_y_reg   <= 31'd65536;
            pitch_reg      <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CURVE_KIND: curve_kind_reg <= cfg_data[1:0];
                REG_CENTER_X:   center_x_reg   <= cfg_data;
                REG_CENTER_Y:   center_y_reg   <= cfg_data;
                REG_RADIUS_X:   radius_x_reg   <= cfg_data[30:0];
                REG_RADIUS_Y:   radius_y_reg   <= cfg_data[30:0];
                REG_PITCH:      pitch_reg      <= cfg_data;
                default:        ;
            endcase
        end
    end

    // helix slope is a function of pitch alone, kept up to date every cycle
    logic [31:0]        sz_mag_reg;
    logic               sz_neg_reg;
    logic [63:0]        sz_prod_reg;
    logic signed [31:0] sz_reg;
    logic [31:0]        sz_round;

    assign sz_round = sz_prod_reg[63:32] + {31'd0, sz_prod_reg[31]};

    always_ff @(posedge clk)
    begin
        sz_neg_reg  <= pitch_reg[31];
        sz_mag_reg  <= pitch_reg[31] ? 32'(-pitch_reg) : pitch_reg;
        sz_prod_reg <= sz_mag_reg * INV_TWO_PI_Q32;
        sz_reg      <= sz_neg_reg ? -signed'(sz_round) : signed'(sz_round);
    end

    // ------------------------------------------------------------------
    // flow control
    // ------------------------------------------------------------------
    logic [D-1:0] vld_reg;
    logic         out_valid_reg;
    logic         adv;
    logic         out_load;

    assign adv      = !vld_reg[D-1] || !out_valid_reg || out_ready;
    assign out_load = !out_valid_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
                vld_reg <= {vld_reg[D-2:0], in_valid};
            if (out_load)
                out_valid_reg <= vld_reg[D-1];
        end
    end

    assign out_valid = out_valid_reg;

    // ------------------------------------------------------------------
    // angle reduction and helix height
    // ------------------------------------------------------------------
    logic signed [31:0] t1_reg;
    logic [31:0]        u2_reg;
    logic [63:0]        prod2_reg;
    logic signed [63:0] pt2_reg;
    logic [31:0]        u3_reg;
    logic [31:0]        qm3_reg;
    logic [62:0]        ptmag3_reg;
    logic               ptneg3_reg;
    logic [MW:0]        rest4_reg;
    logic [63:0]        hi4_reg;
    logic [63:0]        lo4_reg;
    logic               ptneg4_reg;
    logic [MW-1:0]      um5_reg;
    logic [63:0]        q5_reg;
    logic               ptneg5_reg;
    logic [MW-1:0]      r6_reg;
    logic [63:0]        pzmag6_reg;
    logic               ptneg6_reg;
    logic signed [XW-1:0] z7_reg;
    logic               neg7_reg;
    logic signed [31:0] pz7_reg;

    logic [31:0]        u1;
    logic [63:0]        prod2_next;
    logic signed [63:0] pt2_next;
    logic [63:0]        qm_full;
    logic signed [63:0] pt_neg;
    logic [31:0]        diff4;
    logic [MW-1:0]      um5_next;
    logic [MW-1:0]      r6_next;
    logic signed [34:0] a7;
    logic signed [XW-1:0] z7_next;
    logic               neg7_next;
    logic signed [31:0] pz7_next;

    // offset binary keeps the remainder unsigned, the wrap constant fixes it up
    assign u1         = {~t1_reg[31], t1_reg[30:0]};
    assign prod2_next = u1 * RECIP;
    assign pt2_next   = t1_reg * pitch_reg;
    assign qm_full    = prod2_reg[63:32] * M32;
    assign pt_neg     = -pt2_reg;
    assign diff4      = u3_reg - qm3_reg;

    always_comb
    begin
        // quotient estimate may be one short
        if (rest4_reg >= {1'b0, M_W})
            um5_next = MW'(rest4_reg - {1'b0, M_W});
        else
            um5_next = rest4_reg[MW-1:0];

        if (um5_reg >= WRAP_OFF)
            r6_next = um5_reg - WRAP_OFF;
        else
            r6_next = um5_reg + WRAP_ADD;

        // fold into [-pi/2, pi/2], a fold by pi flips both results
        a7        = signed'(35'(r6_reg) << QSH);
        neg7_next = 1'b0;
        if (a7 > PI_Q30)
        begin
            if (a7 < THREE_HALF_PI_Q30)
            begin
                z7_next   = XW'(a7 - PI_Q30);
                neg7_next = 1'b1;
            end
            else
                z7_next = XW'(a7 - TWO_PI_Q30);
        end
        else if (a7 > HALF_PI_Q30)
        begin
            z7_next   = XW'(a7 - PI_Q30);
            neg7_next = 1'b1;
        end
        else
            z7_next = XW'(a7);

        if (ptneg6_reg)
        begin
            if (pzmag6_reg >= 64'h8000_0000)
                pz7_next = 32'sh80000000;
            else
                pz7_next = -signed'(pzmag6_reg[31:0]);
        end
        else
        begin
            if (pzmag6_reg > 64'h7FFF_FFFF)
                pz7_next = 32'sh7FFFFFFF;
            else
                pz7_next = signed'(pzmag6_reg[31:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_reg     <= angle;
            u2_reg     <= u1;
            prod2_reg  <= prod2_next;
            pt2_reg    <= pt2_next;
            u3_reg     <= u2_reg;
            qm3_reg    <= qm_full[31:0];
            ptneg3_reg <= pt2_reg[63];
            ptmag3_reg <= pt2_reg[63] ? pt_neg[62:0] : pt2_reg[62:0];
            rest4_reg  <= diff4[MW:0];
            hi4_reg    <= ptmag3_reg[62:32] * INV_TWO_PI_Q32;
            lo4_reg    <= ptmag3_reg[31:0] * INV_TWO_PI_Q32;
            ptneg4_reg <= ptneg3_reg;
            um5_reg    <= um5_next;
            q5_reg     <= hi4_reg + {32'd0, lo4_reg[63:32]};
            ptneg5_reg <= ptneg4_reg;
            r6_reg     <= r6_next;
            pzmag6_reg <= (q5_reg + RND_F) >> FRACTION_BITS;
            ptneg6_reg <= ptneg5_reg;
            z7_reg     <= z7_next;
            neg7_reg   <= neg7_next;
            pz7_reg    <= pz7_next;
        end
    end

    // ------------------------------------------------------------------
    // rotation pipeline, one stage per rotation
    // ------------------------------------------------------------------
    logic signed [XW-1:0] x_reg [N];
    logic signed [XW-1:0] y_reg [N];
    logic signed [XW-1:0] z_reg [N];
    logic [N-1:0]         neg_pipe_reg;
    logic signed [31:0]   pz_pipe_reg [N];

    logic signed [XW-1:0] x_in [N];
    logic signed [XW-1:0] y_in [N];
    logic signed [XW-1:0] z_in [N];
    logic signed [XW-1:0] x_next [N];
    logic signed [XW-1:0] y_next [N];
    logic signed [XW-1:0] z_next [N];

    always_comb
    begin
        x_in[0] = GAIN_Q30;
        y_in[0] = '0;
        z_in[0] = z7_reg;
        for (int k = 1; k < N; k++)
        begin
            x_in[k] = x_reg[k-1];
            y_in[k] = y_reg[k-1];
            z_in[k] = z_reg[k-1];
        end
        for (int k = 0; k < N; k++)
        begin
            if (!z_in[k][XW-1])
            begin
                x_next[k] = x_in[k] - (y_in[k] >>> k);
                y_next[k] = y_in[k] + (x_in[k] >>> k);
                z_next[k] = z_in[k] - signed'({1'b0, ATAN_Q30[k]});
            end
            else
            begin
                x_next[k] = x_in[k] + (y_in[k] >>> k);
                y_next[k] = y_in[k] - (x_in[k] >>> k);
                z_next[k] = z_in[k] + signed'({1'b0, ATAN_Q30[k]});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg_pipe_reg <= {neg_pipe_reg[N-2:0], neg7_reg};
            pz_pipe_reg[0] <= pz7_reg;
            for (int k = 1; k < N; k++)
                pz_pipe_reg[k] <= pz_pipe_reg[k-1];
            for (int k = 0; k < N; k++)
            begin
                x_reg[k] <= x_next[k];
                y_reg[k] <= y_next[k];
                z_reg[k] <= z_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // radius products and rounding
    // ------------------------------------------------------------------
    logic signed [XW-1:0] cos_reg;
    logic signed [XW-1:0] sin_reg;
    logic signed [XW-1:0] nsin_reg;
    logic signed [31:0]   pza_reg;
    logic signed [63:0]   px_reg;
    logic signed [63:0]   py_reg;
    logic signed [63:0]   pdx_reg;
    logic signed [63:0]   pdy_reg;
    logic signed [31:0]   pzb_reg;
    logic signed [34:0]   sx_reg;
    logic signed [34:0]   sy_reg;
    logic signed [34:0]   sdx_reg;
    logic signed [34:0]   sdy_reg;
    logic signed [31:0]   pzc_reg;

    logic signed [31:0]   rx_s;
    logic signed [31:0]   ry_s;
    logic signed [64:0]   px_full;
    logic signed [64:0]   py_full;
    logic signed [64:0]   pdx_full;
    logic signed [64:0]   pdy_full;
    logic signed [63:0]   sx_full;
    logic signed [63:0]   sy_full;
    logic signed [63:0]   sdx_full;
    logic signed [63:0]   sdy_full;

    assign rx_s     = signed'({1'b0, radius_x_reg});
    assign ry_s     = (curve_kind_reg == KIND_ELLIPSE) ? signed'({1'b0, radius_y_reg}) : rx_s;
    assign px_full  = rx_s * cos_reg;
    assign py_full  = ry_s * sin_reg;
    assign pdx_full = rx_s * nsin_reg;
    assign pdy_full = ry_s * cos_reg;
    assign sx_full  = (px_reg + RND29) >>> 30;
    assign sy_full  = (py_reg + RND29) >>> 30;
    assign sdx_full = (pdx_reg + RND29) >>> 30;
    assign sdy_full = (pdy_reg + RND29) >>> 30;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cos_reg  <= neg_pipe_reg[N-1] ? -x_reg[N-1] : x_reg[N-1];
            sin_reg  <= neg_pipe_reg[N-1] ? -y_reg[N-1] : y_reg[N-1];
            nsin_reg <= neg_pipe_reg[N-1] ? y_reg[N-1] : -y_reg[N-1];
            pza_reg  <= pz_pipe_reg[N-1];
            px_reg   <= px_full[63:0];
            py_reg   <= py_full[63:0];
            pdx_reg  <= pdx_full[63:0];
            pdy_reg  <= pdy_full[63:0];
            pzb_reg  <= pza_reg;
            sx_reg   <= sx_full[34:0];
            sy_reg   <= sy_full[34:0];
            sdx_reg  <= sdx_full[34:0];
            sdy_reg  <= sdy_full[34:0];
            pzc_reg  <= pzb_reg;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic signed [31:0] pos_x_reg;
    logic signed [31:0] pos_y_reg;
    logic signed [31:0] pos_z_reg;
    logic signed [31:0] slope_x_reg;
    logic signed [31:0] slope_y_reg;
    logic signed [31:0] slope_z_reg;
    logic               is_helix;

    assign is_helix = (curve_kind_reg == KIND_HELIX);

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pos_x_reg   <= sat32(64'(center_x_reg) + 64'(sx_reg));
            pos_y_reg   <= sat32(64'(center_y_reg) + 64'(sy_reg));
            pos_z_reg   <= is_helix ? pzc_reg : '0;
            slope_x_reg <= sat32(64'(sdx_reg));
            slope_y_reg <= sat32(64'(sdy_reg));
            slope_z_reg <= is_helix ? sz_reg : '0;
        end
    end

    assign pos_x   = pos_x_reg;
    assign pos_y   = pos_y_reg;
    assign pos_z   = pos_z_reg;
    assign slope_x = slope_x_reg;
    assign slope_y = slope_y_reg;
    assign slope_z = slope_z_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `PCPT_ASSERT_SAME(a_ready_when_last_free, clk, rst_n, !vld_reg[D-1], in_ready,
        "input not ready although the last stage is empty")
    `PCPT_ASSERT_NEXT(a_stall_holds_valids, clk, rst_n, !adv, $stable(vld_reg),
        "pipeline valid bits moved during a stall")
    `PCPT_ASSERT_SAME(a_flat_curve_no_z, clk, rst_n, out_valid && !is_helix,
        pos_z == 32'sd0 && slope_z == 32'sd0, "non-zero z outside the helix")
    `PCPT_ASSERT_NEXT(a_bad_index_ignored, clk, rst_n, cfg_valid && cfg_index > REG_PITCH,
        $stable(curve_kind_reg) && $stable(pitch_reg) && $stable(center_x_reg),
        "write beyond the register map changed a register")

endmodule

`default_nettype wire

### dv/tb_parametric_curve_point_tangent.sv
// ----------------------------------------------------------------------------
// tb_parametric_curve_point_tangent
// drives curve parameters through the point and tangent unit under random
// input gaps and output stalls, outside the burst phases, and checks every result field against a
// local CORDIC-based model of the curve; a directed table comes first, then
// random phases, each with its own curve setup
// ----------------------------------------------------------------------------
`default_nettype none

module tb_parametric_curve_point_tangent;

    import pcpt_pkg::*;

    localparam int STAGES       = CORDIC_STAGES_DEF;
    localparam int FRAC         = FRACTION_BITS_DEF;
    localparam int DRAIN_CYCLES = STAGES + 20;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 50;

    // register indexes beyond the map, writes to them are dropped
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;
    // kind code with no curve of its own, treated as the circle
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic signed [31:0] WORD_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] WORD_MIN = 32'sh80000000;
    localparam logic signed [31:0] QUARTER_TURN = 32'sd102944;

    localparam longint TURN_QF  = longint'((64'hC90FDAA22168C235
                                            + (64'd1 << (60 - FRAC))) >> (61 - FRAC));
    localparam longint HALF_TURN_Q30    = 64'sd3373259426;
    localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
    localparam longint FULL_TURN_Q30    = 64'sd6746518852;
    localparam longint ROT_GAIN_Q30     = 64'sd652032874;
    localparam logic [63:0] RECIP_TURN_Q32 = 64'd683565276;

    typedef longint arctan_t [30];
    localparam arctan_t ARCTAN_Q30 = '{
        'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76,
        'h01FFD55B, 'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD,
        'h000FFFFF, 'h0007FFFF, 'h0003FFFF, 'h0001FFFF, 'h0000FFFF,
        'h00007FFF, 'h00003FFF, 'h00001FFF, 'h00000FFF, 'h000007FF,
        'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F, 'h0000003F,
        'h0000001F, 'h0000000F, 'h00000007, 'h00000003, 'h00000001
    };

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] slope_x;
        logic signed [31:0] slope_y;
        logic signed [31:0] slope_z;
    } curve_sample_t;

    typedef struct packed {
        logic               is_write;
        logic [2:0]         idx;
        logic [31:0]        data;
        logic signed [31:0] t_in;
        logic               typed;
        curve_sample_t      want;
    } step_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] angle;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] slope_x;
    logic signed [31:0] slope_y;
    logic signed [31:0] slope_z;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    // copy of the curve registers as the block should hold them
    logic [1:0]         kind_q;
    logic signed [31:0] ctr_x_q;
    logic signed [31:0] ctr_y_q;
    logic [30:0]        rad_x_q;
    logic [30:0]        rad_y_q;
    logic signed [31:0] pitch_q;

    curve_sample_t pending_samples [$];
    int            mismatch_count = 0;
    bit            burst = 1'b0;

    parametric_curve_point_tangent #(
        .CORDIC_STAGES (STAGES),
        .FRACTION_BITS (FRAC)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .angle     (angle),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .slope_x   (slope_x),
        .slope_y   (slope_y),
        .slope_z   (slope_z),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return WORD_MAX;
        if (v < -64'sd2147483648)
            return WORD_MIN;
        return v[31:0];
    endfunction

    // sine and cosine in Q30 of t reduced to one turn
    function automatic void rotate_unit(input longint t, output longint s, output longint c);
        longint r;
        longint a;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        int     n;
        r = t % TURN_QF;
        if (r < 0)
            r += TURN_QF;
        a = r * (64'sd1 <<< (30 - FRAC));
        if (a > HALF_TURN_Q30)
            a -= FULL_TURN_Q30;
        flip = 1'b0;
        // fold into the right half plane, both results negate
        if (a > QUARTER_TURN_Q30)
        begin
            a -= HALF_TURN_Q30;
            flip = 1'b1;
        end
        else if (a < -QUARTER_TURN_Q30)
        begin
            a += HALF_TURN_Q30;
            flip = 1'b1;
        end
        x = ROT_GAIN_Q30;
        y = 0;
        z = a;
        n = (STAGES < 30) ? STAGES : 30;
        for (int i = 0; i < n; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= ARCTAN_Q30[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += ARCTAN_Q30[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint radius_times(input longint r, input longint trig);
        return (r * trig + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // v / (2 pi), shifted right by extra bits, on the magnitude, rounded half away from zero
    function automatic longint per_turn(input longint v, input int extra);
        bit          neg;
        logic [63:0] m;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] q;
        logic [63:0] res;
        neg = v < 0;
        m   = neg ? -v : v;
        hi  = (m >> 32) * RECIP_TURN_Q32;
        lo  = (m & 64'hFFFFFFFF) * RECIP_TURN_Q32;
        q   = hi + (lo >> 32);
        if (extra == 0)
            res = q + ((lo >> 31) & 64'd1);
        else
            res = (q + (64'd1 << (extra - 1))) >> extra;
        return neg ? -longint'(res) : longint'(res);
    endfunction

    function automatic curve_sample_t curve_sample_at(input logic signed [31:0] t_in);
        curve_sample_t res;
        longint        t;
        longint        s;
        longint        c;
        longint        rx;
        longint        ry;
        longint        pz;
        longint        sz;
        t  = longint'(t_in);
        rotate_unit(t, s, c);
        rx = longint'(rad_x_q);
        ry = (kind_q == KIND_ELLIPSE) ? longint'(rad_y_q) : longint'(rad_x_q);
        pz = 0;
        sz = 0;
        if (kind_q == KIND_HELIX)
        begin
            pz = per_turn(longint'(pitch_q) * t, FRAC);
            sz = per_turn(longint'(pitch_q), 0);
        end
        res.pos_x   = clamp32(longint'(ctr_x_q) + radius_times(rx, c));
        res.pos_y   = clamp32(longint'(ctr_y_q) + radius_times(ry, s));
        res.pos_z   = clamp32(pz);
        res.slope_x = clamp32(radius_times(rx, -s));
        res.slope_y = clamp32(radius_times(ry, c));
        res.slope_z = clamp32(sz);
        return res;
    endfunction

    function automatic step_t cfg_row(input logic [2:0] idx, input logic [31:0] data);
        step_t row;
        row          = '0;
        row.is_write = 1'b1;
        row.idx      = idx;
        row.data     = data;
        return row;
    endfunction

    function automatic step_t item_row(input logic signed [31:0] t_in);
        step_t row;
        row      = '0;
        row.t_in = t_in;
        return row;
    endfunction

    // zero radius: the point is the centre, everything else is zero
    function automatic step_t fixed_row(input logic signed [31:0] t_in,
                                        input logic signed [31:0] px,
                                        input logic signed [31:0] py);
        step_t row;
        row            = '0;
        row.t_in       = t_in;
        row.typed      = 1'b1;
        row.want.pos_x = px;
        row.want.pos_y = py;
        return row;
    endfunction

    step_t directed_steps [$] = '{
        item_row(32'sd0), item_row(WORD_MAX), item_row(WORD_MIN),
        item_row(32'sd1), item_row(-32'sd1), item_row(QUARTER_TURN),
        item_row(32'sd205887), item_row(-32'sd205888),
        item_row(32'sd411775), item_row(32'sd411774),
        cfg_row(REG_RADIUS_X, 32'h0), cfg_row(REG_CENTER_X, WORD_MAX),
        cfg_row(REG_CENTER_Y, WORD_MIN),
        fixed_row(32'sd12345, WORD_MAX, WORD_MIN),
        cfg_row(REG_SPARE_A, 32'hFFFFFFFF), cfg_row(REG_SPARE_B, 32'h00010000),
        fixed_row(WORD_MAX, WORD_MAX, WORD_MIN),
        cfg_row(REG_CURVE_KIND, KIND_HELIX),
        fixed_row(WORD_MIN, WORD_MAX, WORD_MIN),
        cfg_row(REG_CURVE_KIND, KIND_ELLIPSE), cfg_row(REG_CENTER_X, 32'h0),
        cfg_row(REG_CENTER_Y, 32'h0), cfg_row(REG_RADIUS_X, 32'hFFFFFFFF),
        cfg_row(REG_RADIUS_Y, 32'h7FFFFFFF),
        item_row(32'sd0), item_row(QUARTER_TURN), item_row(-32'sd308831),
        cfg_row(REG_CENTER_X, WORD_MAX),
        item_row(32'sd0),
        cfg_row(REG_CURVE_KIND, KIND_HELIX), cfg_row(REG_CENTER_X, 32'h0),
        cfg_row(REG_RADIUS_X, 32'h00010000), cfg_row(REG_PITCH, WORD_MAX),
        item_row(WORD_MAX), item_row(WORD_MIN), item_row(32'sd0),
        cfg_row(REG_PITCH, WORD_MIN),
        item_row(WORD_MIN), item_row(WORD_MAX),
        cfg_row(REG_CURVE_KIND, KIND_UNUSED), cfg_row(REG_CENTER_X, WORD_MIN),
        cfg_row(REG_RADIUS_X, 32'h7FFFFFFF),
        item_row(32'sd205887), item_row(-32'sd1)
    };

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h001FFFFF) - 32'h00100000;
            2: return $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
            default: return 32'h0;
        endcase
    endfunction

    function automatic logic [31:0] random_radius();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h00100000);
            2: return WORD_MAX;
            default: return $urandom_range(0, 32'h0000FFFF);
        endcase
    endfunction

    // half a few turns either side of zero, a quarter near quadrant edges, a quarter any word
    function automatic logic signed [31:0] random_angle();
        int k;
        int off;
        case ($urandom_range(0, 3))
            0: return $urandom;
            3:
            begin
                k   = int'($urandom_range(0, 80)) - 40;
                off = int'($urandom_range(0, 8)) - 4;
                return k * QUARTER_TURN + off;
            end
            default: return $urandom_range(0, 32'h00324000) - 32'h00192000;
        endcase
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        bit took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(negedge clk);
            took = cfg_ready;
            @(posedge clk);
        end
        while (!took);
        case (idx)
            REG_CURVE_KIND: kind_q  = data[1:0];
            REG_CENTER_X:   ctr_x_q = data;
            REG_CENTER_Y:   ctr_y_q = data;
            REG_RADIUS_X:   rad_x_q = data[30:0];
            REG_RADIUS_Y:   rad_y_q = data[30:0];
            REG_PITCH:      pitch_q = data;
            default: ;
        endcase
    endtask

    task automatic send_angle(input logic signed [31:0] t_in, input bit typed,
                              input curve_sample_t want);
        int gap;
        bit took;
        cfg_valid <= 1'b0;
        gap = burst ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        angle    <= t_in;
        do
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
        while (!took);
        pending_samples.push_back(typed ? want : curve_sample_at(t_in));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_setup(input int phase);
        write_reg(REG_CURVE_KIND, phase % 4);
        write_reg(REG_CENTER_X, random_word());
        write_reg(REG_CENTER_Y, random_word());
        write_reg(REG_RADIUS_X, random_radius());
        write_reg(REG_RADIUS_Y, random_radius());
        write_reg(REG_PITCH, random_word());
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want)
        begin
            $display("%0t %s: expected %0d (%08h), actual %0d (%08h)",
                     $time, name, want, want, got, got);
            mismatch_count++;
        end
    endtask

    // sampled mid-cycle, the transaction itself happens at the next rising edge
    always @(negedge clk)
    begin : result_check
        curve_sample_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_samples.size() == 0)
            begin
                $display("%0t result with none pending: expected nothing, actual %08h %08h",
                         $time, pos_x, pos_y);
                mismatch_count++;
            end
            else
            begin
                want = pending_samples.pop_front();
                check_field("pos_x", want.pos_x, pos_x);
                check_field("pos_y", want.pos_y, pos_y);
                check_field("pos_z", want.pos_z, pos_z);
                check_field("slope_x", want.slope_x, slope_x);
                check_field("slope_y", want.slope_y, slope_y);
                check_field("slope_z", want.slope_z, slope_z);
            end
        end
    end

    initial
    begin : result_sink
        int stall;
        bit took;
        out_ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = burst ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
            begin
                @(negedge clk);
                took = out_valid;
                @(posedge clk);
            end
            while (!took);
        end
    end

    initial
    begin : stimulus
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        angle     <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_CURVE_KIND;
        cfg_data  <= '0;
        kind_q    = KIND_CIRCLE;
        ctr_x_q   = '0;
        ctr_y_q   = '0;
        rad_x_q   = 31'h00010000;
        rad_y_q   = 31'h00010000;
        pitch_q   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].is_write)
            begin
                wait_idle();
                write_reg(directed_steps[i].idx, directed_steps[i].data);
            end
            else
                send_angle(directed_steps[i].t_in, directed_steps[i].typed,
                           directed_steps[i].want);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            burst = (phase == 2 || phase == 5);
            random_setup(phase);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // hold off mid-phase until the pipeline has emptied
                if (phase == 3 && n == PHASE_ITEMS / 2)
                    wait_idle();
                send_angle(random_angle(), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
